[sv/blc_pkg.sv]
// ----------------------------------------------------------------------------
// blc_pkg
// Shared types, constants and the bracket decoder for the line checker.
// ----------------------------------------------------------------------------
package blc_pkg;

	// Stack geometry
	localparam int STACK_DEPTH = 32;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	localparam int WEIGHT_W  = 16;
	localparam int SCORE_W   = 64;
	localparam int DEPTH_W   = 6;
	localparam int CFG_IDX_W = 8;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_ROUND  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_SQUARE = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_CURLY  = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_ANGLE  = 8'd3;

	localparam logic [WEIGHT_W-1:0] WEIGHT_ROUND_RST  = 16'd3;
	localparam logic [WEIGHT_W-1:0] WEIGHT_SQUARE_RST = 16'd57;
	localparam logic [WEIGHT_W-1:0] WEIGHT_CURLY_RST  = 16'd1197;
	localparam logic [WEIGHT_W-1:0] WEIGHT_ANGLE_RST  = 16'd25137;

	// ASCII codes of the brackets
	localparam logic [7:0] CH_ROUND_OPEN   = 8'h28;
	localparam logic [7:0] CH_ROUND_CLOSE  = 8'h29;
	localparam logic [7:0] CH_SQUARE_OPEN  = 8'h5B;
	localparam logic [7:0] CH_SQUARE_CLOSE = 8'h5D;
	localparam logic [7:0] CH_CURLY_OPEN   = 8'h7B;
	localparam logic [7:0] CH_CURLY_CLOSE  = 8'h7D;
	localparam logic [7:0] CH_ANGLE_OPEN   = 8'h3C;
	localparam logic [7:0] CH_ANGLE_CLOSE  = 8'h3E;

	typedef enum logic [1:0] {
		KIND_ROUND  = 2'd0,
		KIND_SQUARE = 2'd1,
		KIND_CURLY  = 2'd2,
		KIND_ANGLE  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_BALANCED   = 2'd0,
		ST_INCOMPLETE = 2'd1,
		ST_CORRUPT    = 2'd2,
		ST_OVERFLOW   = 2'd3
	} line_status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_FINISH,
		S_WALK,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic [7:0] symbol;
		logic       line_end;
	} sym_t;

	typedef struct packed {
		line_status_t         line_status;
		logic [1:0]           bad_kind;
		logic [WEIGHT_W-1:0]  line_error_score;
		logic [SCORE_W-1:0]   error_total;
		logic [SCORE_W-1:0]   completion_score;
		logic [DEPTH_W-1:0]   open_depth;
	} res_t;

	typedef struct packed {
		logic  clr;
		logic  push;
		logic  pop;
		kind_t kind;
	} stack_op_t;

	typedef struct packed {
		logic  is_br;
		logic  is_open;
		kind_t kind;
	} sym_class_t;

	function automatic sym_class_t classify(input logic [7:0] c);
		sym_class_t r;
		r = '{is_br: 1'b1, is_open: 1'b0, kind: KIND_ROUND};
		unique case (c)
			CH_ROUND_OPEN:   begin r.is_open = 1'b1; r.kind = KIND_ROUND;  end
			CH_SQUARE_OPEN:  begin r.is_open = 1'b1; r.kind = KIND_SQUARE; end
			CH_CURLY_OPEN:   begin r.is_open = 1'b1; r.kind = KIND_CURLY;  end
			CH_ANGLE_OPEN:   begin r.is_open = 1'b1; r.kind = KIND_ANGLE;  end
			CH_ROUND_CLOSE:  r.kind = KIND_ROUND;
			CH_SQUARE_CLOSE: r.kind = KIND_SQUARE;
			CH_CURLY_CLOSE:  r.kind = KIND_CURLY;
			CH_ANGLE_CLOSE:  r.kind = KIND_ANGLE;
			default:         r.is_br = 1'b0;
		endcase
		return r;
	endfunction

endpackage

[sv/blc_stack.sv]
// ----------------------------------------------------------------------------
// blc_stack
// Opener stack: kind storage, fill count and one read port.
// ----------------------------------------------------------------------------
module blc_stack (
	input  logic                     clk,
	input  logic                     arst_n,
	input  blc_pkg::stack_op_t       op,
	input  logic [blc_pkg::IDX_W-1:0] rd_addr,
	output blc_pkg::kind_t           rd_kind,
	output logic [blc_pkg::CNT_W-1:0] count
);

	blc_pkg::kind_t                stack_q [blc_pkg::STACK_DEPTH];
	logic [blc_pkg::CNT_W-1:0]     count_q;
	logic [blc_pkg::IDX_W-1:0]     wr_addr;

	assign wr_addr = count_q[blc_pkg::IDX_W-1:0];

	always_ff @(posedge clk) begin
		if (op.push && !op.clr) begin
			stack_q[wr_addr] <= op.kind;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (op.clr) begin
			count_q <= '0;
		end else if (op.push) begin
			count_q <= count_q + blc_pkg::CNT_W'(1);
		end else if (op.pop) begin
			count_q <= count_q - blc_pkg::CNT_W'(1);
		end
	end

	assign rd_kind = stack_q[rd_addr];
	assign count   = count_q;

endmodule

[sv/blc_horner.sv]
// ----------------------------------------------------------------------------
// blc_horner
// Saturating base-5 multiply-add, stepped once per stack entry from the top.
// ----------------------------------------------------------------------------
module blc_horner (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [blc_pkg::CNT_W-1:0]   depth,
	input  blc_pkg::kind_t              kind,
	output logic [blc_pkg::IDX_W-1:0]   walk_addr,
	output logic                        last,
	output logic [blc_pkg::SCORE_W-1:0] acc
);

	logic [blc_pkg::CNT_W-1:0]   idx_q;
	logic [blc_pkg::SCORE_W-1:0] acc_q;
	logic [blc_pkg::SCORE_W+2:0] sum;
	logic [blc_pkg::SCORE_W-1:0] step;

	// acc * 5 + (kind + 1); anything above 64 bits saturates
	always_comb begin
		sum  = {1'b0, acc_q, 2'b00}
			+ {3'b000, acc_q}
			+ (blc_pkg::SCORE_W + 3)'({1'b0, kind} + 3'd1);
		step = (sum[blc_pkg::SCORE_W+2:blc_pkg::SCORE_W] != 3'b000)
			? {blc_pkg::SCORE_W{1'b1}} : sum[blc_pkg::SCORE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (start) begin
			idx_q <= depth;
		end else if (idx_q != '0) begin
			idx_q <= idx_q - blc_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
		end else if (idx_q != '0) begin
			acc_q <= step;
		end
	end

	assign walk_addr = blc_pkg::IDX_W'(idx_q - blc_pkg::CNT_W'(1));
	assign last      = (idx_q == blc_pkg::CNT_W'(1));
	assign acc       = acc_q;

endmodule

[sv/bracket_line_checker.sv]
// ----------------------------------------------------------------------------
// bracket_line_checker
// Per-line bracket balance checker with error and completion scoring.
// ----------------------------------------------------------------------------
// Each accepted beat on the symbol channel is one byte; an ordinary byte
// leaves the block ready for the next. The byte that ends a line holds the
// symbol channel while the line is finished: the line is first classified;
// for an incomplete line a single saturating multiply-add then walks the
// stack from top to bottom to form the completion score; last, the result
// register is loaded. The result register frees the input side, so the next
// line streams in while a result waits; only a second line end waits for that
// result to be taken.
// Weight writes on the config port are always ready.
// ----------------------------------------------------------------------------
module bracket_line_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          sym_valid,
	output logic                          sym_stall,
	input  blc_pkg::sym_t                 sym_item,
	output logic                          res_valid,
	input  logic                          res_stall,
	output blc_pkg::res_t                 res_item,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [blc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [blc_pkg::WEIGHT_W-1:0]  cfg_data
);

	blc_pkg::state_t               state_q, state_d;
	logic [blc_pkg::WEIGHT_W-1:0]  weight_q [4];

	logic                          corrupt_q;
	logic                          overflow_q;
	blc_pkg::kind_t                corrupt_kind_q;
	logic [blc_pkg::WEIGHT_W-1:0]  corrupt_weight_q;
	logic [blc_pkg::SCORE_W-1:0]   weight_sum_q;
	logic                          res_valid_q;
	blc_pkg::res_t                 res_q;

	blc_pkg::stack_op_t            stk_op;
	logic [blc_pkg::IDX_W-1:0]     stk_addr;
	blc_pkg::kind_t                stk_kind;
	logic [blc_pkg::CNT_W-1:0]     stk_count;

	logic                          hrn_start;
	logic [blc_pkg::IDX_W-1:0]     hrn_addr;
	logic                          hrn_last;
	logic [blc_pkg::SCORE_W-1:0]   hrn_acc;

	logic                          accept;
	logic                          emit;
	logic                          incomplete;
	blc_pkg::sym_class_t           cls;
	logic                          active;
	logic                          full;
	logic                          mismatch;
	logic                          set_overflow;
	logic                          set_corrupt;
	logic [blc_pkg::SCORE_W:0]     sum_ext;
	logic [blc_pkg::SCORE_W-1:0]   sum_sat;
	blc_pkg::res_t                 res_d;

	// ------------------------------------------------------------------
	// Configuration
	// ------------------------------------------------------------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q[blc_pkg::KIND_ROUND]  <= blc_pkg::WEIGHT_ROUND_RST;
			weight_q[blc_pkg::KIND_SQUARE] <= blc_pkg::WEIGHT_SQUARE_RST;
			weight_q[blc_pkg::KIND_CURLY]  <= blc_pkg::WEIGHT_CURLY_RST;
			weight_q[blc_pkg::KIND_ANGLE]  <= blc_pkg::WEIGHT_ANGLE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				blc_pkg::REG_WEIGHT_ROUND:  weight_q[blc_pkg::KIND_ROUND]  <= cfg_data;
				blc_pkg::REG_WEIGHT_SQUARE: weight_q[blc_pkg::KIND_SQUARE] <= cfg_data;
				blc_pkg::REG_WEIGHT_CURLY:  weight_q[blc_pkg::KIND_CURLY]  <= cfg_data;
				blc_pkg::REG_WEIGHT_ANGLE:  weight_q[blc_pkg::KIND_ANGLE]  <= cfg_data;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	assign incomplete = !corrupt_q && !overflow_q && (stk_count != '0);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			blc_pkg::S_IDLE:   if (accept && sym_item.line_end) begin
				state_d = blc_pkg::S_FINISH;
			end
			blc_pkg::S_FINISH: state_d = incomplete ? blc_pkg::S_WALK : blc_pkg::S_EMIT;
			blc_pkg::S_WALK:   if (hrn_last) begin
				state_d = blc_pkg::S_EMIT;
			end
			blc_pkg::S_EMIT:   if (emit) begin
				state_d = blc_pkg::S_IDLE;
			end
			default:           state_d = blc_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		sym_stall = (state_q != blc_pkg::S_IDLE);
		accept    = sym_valid && !sym_stall;
		emit      = (state_q == blc_pkg::S_EMIT) && (!res_valid_q || !res_stall);
		hrn_start = (state_q == blc_pkg::S_FINISH) && incomplete;
		stk_addr  = (state_q == blc_pkg::S_WALK) ? hrn_addr
			: blc_pkg::IDX_W'(stk_count - blc_pkg::CNT_W'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= blc_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ------------------------------------------------------------------
	// Byte handling: push, pop or mark the line
	// ------------------------------------------------------------------
	always_comb begin
		cls          = blc_pkg::classify(sym_item.symbol);
		active       = accept && cls.is_br && !corrupt_q && !overflow_q;
		full         = (stk_count == blc_pkg::CNT_W'(blc_pkg::STACK_DEPTH));
		mismatch     = (stk_count == '0) || (stk_kind != cls.kind);
		set_overflow = active && cls.is_open && full;
		set_corrupt  = active && !cls.is_open && mismatch;
		stk_op.clr   = emit;
		stk_op.push  = active && cls.is_open && !full;
		stk_op.pop   = active && !cls.is_open && !mismatch;
		stk_op.kind  = cls.kind;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corrupt_q      <= 1'b0;
			overflow_q     <= 1'b0;
			corrupt_kind_q <= blc_pkg::KIND_ROUND;
		end else if (emit) begin
			corrupt_q      <= 1'b0;
			overflow_q     <= 1'b0;
			corrupt_kind_q <= blc_pkg::KIND_ROUND;
		end else begin
			if (set_overflow) begin
				overflow_q <= 1'b1;
			end
			if (set_corrupt) begin
				corrupt_q      <= 1'b1;
				corrupt_kind_q <= cls.kind;
			end
		end
	end

	// latch the weight as it stands when the bad closer arrives
	always_ff @(posedge clk) begin
		if (set_corrupt) begin
			corrupt_weight_q <= weight_q[cls.kind];
		end
	end

	// ------------------------------------------------------------------
	// Result formation
	// ------------------------------------------------------------------
	always_comb begin
		sum_ext = {1'b0, weight_sum_q} + (blc_pkg::SCORE_W + 1)'(corrupt_weight_q);
		sum_sat = sum_ext[blc_pkg::SCORE_W] ? {blc_pkg::SCORE_W{1'b1}}
			: sum_ext[blc_pkg::SCORE_W-1:0];

		res_d.bad_kind         = blc_pkg::KIND_ROUND;
		res_d.line_error_score = '0;
		res_d.error_total      = weight_sum_q;
		res_d.completion_score = '0;
		res_d.open_depth       = blc_pkg::DEPTH_W'(stk_count);
		priority if (corrupt_q) begin
			res_d.line_status      = blc_pkg::ST_CORRUPT;
			res_d.bad_kind         = corrupt_kind_q;
			res_d.line_error_score = corrupt_weight_q;
			res_d.error_total      = sum_sat;
		end else if (overflow_q) begin
			res_d.line_status      = blc_pkg::ST_OVERFLOW;
		end else if (stk_count == '0) begin
			res_d.line_status      = blc_pkg::ST_BALANCED;
		end else begin
			res_d.line_status      = blc_pkg::ST_INCOMPLETE;
			res_d.completion_score = hrn_acc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_sum_q <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			if (emit) begin
				weight_sum_q <= res_d.error_total;
				res_valid_q  <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_q;

	// ------------------------------------------------------------------
	// Datapath units
	// ------------------------------------------------------------------
	blc_stack u_stack (
		.clk     (clk),
		.arst_n  (arst_n),
		.op      (stk_op),
		.rd_addr (stk_addr),
		.rd_kind (stk_kind),
		.count   (stk_count)
	);

	blc_horner u_horner (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (hrn_start),
		.depth     (stk_count),
		.kind      (stk_kind),
		.walk_addr (hrn_addr),
		.last      (hrn_last),
		.acc       (hrn_acc)
	);

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stk_count <= blc_pkg::CNT_W'(blc_pkg::STACK_DEPTH))
		else $error("opener stack count beyond depth");

	a_no_byte_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == blc_pkg::S_WALK) |=> !$past(stk_op.push) && !$past(stk_op.pop))
		else $error("stack changed during completion walk");

	a_score_only_incomplete: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_item.completion_score != '0)
		|-> res_item.line_status == blc_pkg::ST_INCOMPLETE)
		else $error("completion score on a line that is not incomplete");

	a_error_only_corrupt: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_item.line_status != blc_pkg::ST_CORRUPT)
		|-> (res_item.line_error_score == '0) && (res_item.bad_kind == blc_pkg::KIND_ROUND))
		else $error("error score on a line that is not corrupt");

	a_total_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> weight_sum_q >= $past(weight_sum_q))
		else $error("error total went down");

endmodule

[sim/bracket_line_checker_tb.sv]
// ----------------------------------------------------------------------------
// bracket_line_checker_tb
// Self-checking bench for the bracket line checker. Bytes are streamed on the
// symbol channel, first as a short table of hand-picked lines, then as random
// lines that are mostly well nested. A line scorer inside the bench tracks the
// opener stack and the weights, and each result beat is compared field by
// field with the oldest pending line. Weights are reloaded between phases, and
// both sides insert gaps at varying rates.
// ----------------------------------------------------------------------------
module bracket_line_checker_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int          CYCLE_LIMIT = 400000;
	localparam int          SETTLE      = 2 * blc_pkg::STACK_DEPTH + 8;
	localparam logic [63:0] SCORE_MAX   = '1;

	// unused register indexes, writes there must not land anywhere
	localparam logic [blc_pkg::CFG_IDX_W-1:0] REG_SPARE_FIRST = 8'd4;
	localparam logic [blc_pkg::CFG_IDX_W-1:0] REG_SPARE_LAST  = 8'hFF;

	localparam logic [7:0] OPEN_CH [4] = '{blc_pkg::CH_ROUND_OPEN,
		blc_pkg::CH_SQUARE_OPEN, blc_pkg::CH_CURLY_OPEN, blc_pkg::CH_ANGLE_OPEN};
	localparam logic [7:0] CLOSE_CH [4] = '{blc_pkg::CH_ROUND_CLOSE,
		blc_pkg::CH_SQUARE_CLOSE, blc_pkg::CH_CURLY_CLOSE, blc_pkg::CH_ANGLE_CLOSE};

	typedef struct {
		string                        body;
		int                           reps;
		bit                           lead_nul;
		bit                           typed;
		blc_pkg::line_status_t        st;
		blc_pkg::kind_t               kind;
		logic [blc_pkg::WEIGHT_W-1:0] score;
		logic [blc_pkg::SCORE_W-1:0]  total;
		logic [blc_pkg::SCORE_W-1:0]  comp;
		logic [blc_pkg::DEPTH_W-1:0]  depth;
	} line_row_t;

	typedef struct {
		bit            typed;
		blc_pkg::res_t want;
	} typed_line_t;

	logic                            clk;
	logic                            arst_n;
	logic                            sym_valid;
	logic                            sym_stall;
	blc_pkg::sym_t                   sym_item;
	logic                            res_valid;
	logic                            res_stall;
	blc_pkg::res_t                   res_item;
	logic                            cfg_valid;
	logic                            cfg_ready;
	logic [blc_pkg::CFG_IDX_W-1:0]   cfg_index;
	logic [blc_pkg::WEIGHT_W-1:0]    cfg_data;

	// line scorer state
	logic [blc_pkg::WEIGHT_W-1:0]    weight_r [4];
	blc_pkg::kind_t                  open_kinds [blc_pkg::STACK_DEPTH];
	int                              open_cnt;
	bit                              line_bad;
	bit                              line_full;
	blc_pkg::kind_t                  bad_kind_r;
	logic [blc_pkg::WEIGHT_W-1:0]    bad_weight_r;
	logic [blc_pkg::SCORE_W-1:0]     score_total;

	blc_pkg::res_t                   pending_lines [$];
	typed_line_t                     typed_lines [$];
	int                              tx_idle_pct;
	int                              rx_idle_pct;
	int                              n_err;
	int                              n_lines;
	int                              n_bytes;
	int                              status_seen [4];
	int                              cycle_cnt;
	bit                              line_done;
	blc_pkg::res_t                   line_res;
	typed_line_t                     tline;

	// expected values typed in where they follow directly from reset weights
	line_row_t dir_rows [13] = '{
		'{"()",        1,  1'b0, 1'b1, blc_pkg::ST_BALANCED,   blc_pkg::KIND_ROUND,
			16'd0,     64'd0,     64'd0,     6'd0},
		'{"x[<a>{}]9", 1,  1'b0, 1'b0, blc_pkg::ST_BALANCED,   blc_pkg::KIND_ROUND,
			16'd0,     64'd0,     64'd0,     6'd0},
		'{"(]",        1,  1'b0, 1'b1, blc_pkg::ST_CORRUPT,    blc_pkg::KIND_SQUARE,
			16'd57,    64'd57,    64'd0,     6'd1},
		'{")",         1,  1'b0, 1'b1, blc_pkg::ST_CORRUPT,    blc_pkg::KIND_ROUND,
			16'd3,     64'd60,    64'd0,     6'd0},
		'{"{>",        1,  1'b0, 1'b1, blc_pkg::ST_CORRUPT,    blc_pkg::KIND_ANGLE,
			16'd25137, 64'd25197, 64'd0,     6'd1},
		'{"<}",        1,  1'b0, 1'b1, blc_pkg::ST_CORRUPT,    blc_pkg::KIND_CURLY,
			16'd1197,  64'd26394, 64'd0,     6'd1},
		'{"([{<",      1,  1'b0, 1'b1, blc_pkg::ST_INCOMPLETE, blc_pkg::KIND_ROUND,
			16'd0,     64'd26394, 64'd586,   6'd4},
		'{"(",         33, 1'b0, 1'b1, blc_pkg::ST_OVERFLOW,   blc_pkg::KIND_ROUND,
			16'd0,     64'd26394, 64'd0,     6'd32},
		'{"<",         32, 1'b0, 1'b1, blc_pkg::ST_INCOMPLETE, blc_pkg::KIND_ROUND,
			16'd0,     64'd26394, SCORE_MAX, 6'd32},
		'{"(",         32, 1'b0, 1'b0, blc_pkg::ST_BALANCED,   blc_pkg::KIND_ROUND,
			16'd0,     64'd0,     64'd0,     6'd0},
		'{"(]((((]",   1,  1'b0, 1'b0, blc_pkg::ST_BALANCED,   blc_pkg::KIND_ROUND,
			16'd0,     64'd0,     64'd0,     6'd0},
		'{"\377abc",   1,  1'b1, 1'b1, blc_pkg::ST_BALANCED,   blc_pkg::KIND_ROUND,
			16'd0,     64'd26451, 64'd0,     6'd0},
		'{"()]",       1,  1'b0, 1'b1, blc_pkg::ST_CORRUPT,    blc_pkg::KIND_SQUARE,
			16'd57,    64'd26508, 64'd0,     6'd0}
	};

	bracket_line_checker uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sym_valid (sym_valid),
		.sym_stall (sym_stall),
		.sym_item  (sym_item),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic void decode_symbol(input logic [7:0] c, output bit br,
		output bit opener, output blc_pkg::kind_t k);
		br = 1'b0;
		opener = 1'b0;
		k = blc_pkg::KIND_ROUND;
		for (int i = 0; i < 4; i++) begin
			if (c == OPEN_CH[i]) begin
				br = 1'b1;
				opener = 1'b1;
				k = blc_pkg::kind_t'(i);
			end
			if (c == CLOSE_CH[i]) begin
				br = 1'b1;
				k = blc_pkg::kind_t'(i);
			end
		end
	endfunction

	function automatic void drop_line_state();
		open_cnt = 0;
		line_bad = 1'b0;
		line_full = 1'b0;
		bad_kind_r = blc_pkg::KIND_ROUND;
		bad_weight_r = '0;
	endfunction

	// Apply one byte to the scorer; on a line end, form the line's result.
	function automatic void scan_byte(input blc_pkg::sym_t b, output bit done,
		output blc_pkg::res_t r);
		bit                          br;
		bit                          opener;
		blc_pkg::kind_t              k;
		logic [blc_pkg::SCORE_W-1:0] comp;
		logic [blc_pkg::SCORE_W-1:0] v;
		done = 1'b0;
		r = '0;
		comp = '0;
		decode_symbol(b.symbol, br, opener, k);
		if (br && !line_bad && !line_full) begin
			if (opener) begin
				if (open_cnt >= blc_pkg::STACK_DEPTH) begin
					line_full = 1'b1;
				end else begin
					open_kinds[open_cnt] = k;
					open_cnt++;
				end
			end else if (open_cnt == 0 || open_kinds[open_cnt-1] != k) begin
				line_bad = 1'b1;
				bad_kind_r = k;
				bad_weight_r = weight_r[k];
			end else begin
				open_cnt--;
			end
		end
		if (!b.line_end)
			return;
		done = 1'b1;
		if (line_bad) begin
			r.line_status = blc_pkg::ST_CORRUPT;
			r.bad_kind = bad_kind_r;
			r.line_error_score = bad_weight_r;
			score_total = (score_total > SCORE_MAX - 64'(bad_weight_r)) ? SCORE_MAX
				: score_total + 64'(bad_weight_r);
		end else if (line_full) begin
			r.line_status = blc_pkg::ST_OVERFLOW;
		end else if (open_cnt == 0) begin
			r.line_status = blc_pkg::ST_BALANCED;
		end else begin
			r.line_status = blc_pkg::ST_INCOMPLETE;
			// Horner walk from the top of the stack, saturating
			for (int i = open_cnt - 1; i >= 0; i--) begin
				v = 64'(open_kinds[i]) + 64'd1;
				comp = (comp > (SCORE_MAX - v) / 5) ? SCORE_MAX : comp * 5 + v;
			end
		end
		r.error_total = score_total;
		r.completion_score = comp;
		r.open_depth = blc_pkg::DEPTH_W'(open_cnt);
		drop_line_state();
	endfunction

	task automatic cmp_field(input string name, input logic [63:0] want,
		input logic [63:0] got);
		if (got !== want) begin
			n_err++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	task automatic check_line(input blc_pkg::res_t got);
		blc_pkg::res_t want;
		if (pending_lines.size() == 0) begin
			n_err++;
			$display("%0t: result beat with no line pending, expected none, got %0h",
				$time, got);
			return;
		end
		want = pending_lines.pop_front();
		n_lines++;
		cmp_field("line_status", 64'(want.line_status), 64'(got.line_status));
		cmp_field("bad_kind", 64'(want.bad_kind), 64'(got.bad_kind));
		cmp_field("line_error_score", 64'(want.line_error_score),
			64'(got.line_error_score));
		cmp_field("error_total", want.error_total, got.error_total);
		cmp_field("completion_score", want.completion_score, got.completion_score);
		cmp_field("open_depth", 64'(want.open_depth), 64'(got.open_depth));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_r[blc_pkg::KIND_ROUND] = blc_pkg::WEIGHT_ROUND_RST;
			weight_r[blc_pkg::KIND_SQUARE] = blc_pkg::WEIGHT_SQUARE_RST;
			weight_r[blc_pkg::KIND_CURLY] = blc_pkg::WEIGHT_CURLY_RST;
			weight_r[blc_pkg::KIND_ANGLE] = blc_pkg::WEIGHT_ANGLE_RST;
			score_total = '0;
			drop_line_state();
		end else begin
			if (res_valid && !res_stall)
				check_line(res_item);
			if (cfg_valid && cfg_ready && cfg_index <= blc_pkg::REG_WEIGHT_ANGLE)
				weight_r[cfg_index[1:0]] = cfg_data;
			if (sym_valid && !sym_stall) begin
				n_bytes++;
				scan_byte(sym_item, line_done, line_res);
				if (line_done) begin
					if (typed_lines.size() != 0) begin
						tline = typed_lines.pop_front();
						if (tline.typed)
							line_res = tline.want;
					end
					status_seen[line_res.line_status]++;
					pending_lines.insert(pending_lines.size(), line_res);
				end
			end
		end
	end

	always @(negedge clk)
		res_stall <= ($urandom_range(0, 99) < rx_idle_pct);

	// Called at a falling edge; returns at the falling edge after the beat.
	task automatic send_byte(input blc_pkg::sym_t b);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			sym_valid <= 1'b0;
			@(negedge clk);
		end
		sym_item <= b;
		sym_valid <= 1'b1;
		do @(posedge clk); while (sym_stall);
		@(negedge clk);
	endtask

	task automatic write_weight(input logic [blc_pkg::CFG_IDX_W-1:0] idx,
		input logic [blc_pkg::WEIGHT_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	task automatic load_weights(input logic [blc_pkg::WEIGHT_W-1:0] w_round, w_square,
		w_curly, w_angle, input logic [blc_pkg::CFG_IDX_W-1:0] spare_idx,
		input logic [blc_pkg::WEIGHT_W-1:0] spare_val);
		write_weight(blc_pkg::REG_WEIGHT_ROUND, w_round);
		write_weight(blc_pkg::REG_WEIGHT_SQUARE, w_square);
		write_weight(blc_pkg::REG_WEIGHT_CURLY, w_curly);
		write_weight(blc_pkg::REG_WEIGHT_ANGLE, w_angle);
		write_weight(spare_idx, spare_val);
		cfg_valid <= 1'b0;
	endtask

	// Drop valid, wait for every pending line, then let the block settle.
	task automatic drain();
		sym_valid <= 1'b0;
		while (pending_lines.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic send_row(input line_row_t row);
		blc_pkg::sym_t b;
		int            len;
		typed_line_t   ent;
		if (row.lead_nul) begin
			b.symbol = 8'h00;
			b.line_end = 1'b0;
			send_byte(b);
		end
		len = row.reps * row.body.len();
		for (int j = 0; j < len; j++) begin
			b.symbol = row.body[j % row.body.len()];
			b.line_end = (j == len - 1);
			if (b.line_end) begin
				ent.typed = row.typed;
				ent.want = '0;
				ent.want.line_status = row.st;
				ent.want.bad_kind = row.kind;
				ent.want.line_error_score = row.score;
				ent.want.error_total = row.total;
				ent.want.completion_score = row.comp;
				ent.want.open_depth = row.depth;
				typed_lines.insert(typed_lines.size(), ent);
			end
			send_byte(b);
		end
	endtask

	// Mostly well nested lines, some wrong closers and stray bytes; a few deep
	// ones push the stack to its limit and past it.
	task automatic send_random_line(inout int active);
		blc_pkg::sym_t  b;
		blc_pkg::kind_t opened [$];
		blc_pkg::kind_t k;
		bit             deep;
		int             len;
		int             p_open;
		int             r;
		deep = ($urandom_range(0, 19) == 0);
		len = deep ? $urandom_range(32, 48) : $urandom_range(1, 12);
		p_open = deep ? 90 : 40;
		for (int i = 0; i < len; i++) begin
			r = $urandom_range(0, 99);
			k = blc_pkg::kind_t'($urandom_range(0, 3));
			if (r < p_open) begin
				b.symbol = OPEN_CH[k];
				opened.insert(opened.size(), k);
			end else if (r < 85) begin
				if (opened.size() != 0 && $urandom_range(0, 9) != 0)
					k = opened.pop_back();
				b.symbol = CLOSE_CH[k];
			end else begin
				b.symbol = 8'($urandom_range(0, 255));
			end
			b.line_end = (i == len - 1);
			active++;
			send_byte(b);
		end
	endtask

	task automatic run_random(input int tx, input int rx, input int goal);
		int active;
		active = 0;
		tx_idle_pct = tx;
		rx_idle_pct = rx;
		while (active < goal)
			send_random_line(active);
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		sym_valid = 1'b0;
		sym_item = '0;
		res_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		n_err = 0;
		n_lines = 0;
		n_bytes = 0;
		status_seen = '{0, 0, 0, 0};
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		tx_idle_pct = 33;
		rx_idle_pct = 60;
		foreach (dir_rows[n])
			send_row(dir_rows[n]);
		drain();

		load_weights('1, '1, '1, '1, REG_SPARE_LAST, 16'h1234);
		run_random(33, 60, 439);

		load_weights('0, '0, '0, '0, REG_SPARE_FIRST, 16'hA5A5);
		run_random(60, 33, 439);

		load_weights(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
			16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
			REG_SPARE_FIRST, 16'($urandom_range(0, 65535)));
		run_random(0, 0, 438);

		$display("%0d line results checked over %0d bytes:", n_lines, n_bytes);
		$display("%0d balanced, %0d incomplete, %0d corrupt, %0d overflowed",
			status_seen[blc_pkg::ST_BALANCED], status_seen[blc_pkg::ST_INCOMPLETE],
			status_seen[blc_pkg::ST_CORRUPT], status_seen[blc_pkg::ST_OVERFLOW]);
		$display("weights at reset, all ones, all zeros and random; gaps on either side, then none");
		if (n_err == 0 && pending_lines.size() == 0) begin
			$display("** bracket_line_checker: PASSED **");
		end else begin
			$display("** bracket_line_checker: FAILED **");
		end
		$finish;
	end

	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("%0t: no progress after %0d cycles, %0d lines pending", $time, cycle_cnt,
			pending_lines.size());
		$display("** bracket_line_checker: FAILED **");
		$finish;
	end

endmodule

[filelist.f]
sv/blc_pkg.sv
sv/blc_stack.sv
sv/blc_horner.sv
sv/bracket_line_checker.sv
sim/bracket_line_checker_tb.sv
